/* rtl/fvn_pkg.sv */
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared constants and types of the fractal value noise cloud pixel core.
// ----------------------------------------------------------------------------
package fvn_pkg;

    // Default parameter values of the core.
    localparam int DEF_COORD_BITS  = 16;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_MAX_OCTAVES = 8;

    // Lattice hash multipliers, all in 32-bit wrapping arithmetic.
    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd3266489917;
    localparam int          HASH_SHIFT   = 15;

    // Width of the octave count register.
    localparam int OCT_W = 4;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_NOISE_SEED   = 3'd0,
        REG_OCTAVE_COUNT = 3'd1,
        REG_FIRST_RED    = 3'd2,
        REG_FIRST_GREEN  = 3'd3,
        REG_FIRST_BLUE   = 3'd4,
        REG_SECOND_RED   = 3'd5,
        REG_SECOND_GREEN = 3'd6,
        REG_SECOND_BLUE  = 3'd7
    } reg_index_t;

    // Signed Q1.15 lattice value.
    typedef logic signed [15:0] noise_value_t;

endpackage

/* rtl/fractal_value_noise_cloud_pixel_core.sv */
// ----------------------------------------------------------------------------
// fractal_value_noise_cloud_pixel_core
// Fractal value noise cloud texture: one pixel coordinate in, one color out.
// ----------------------------------------------------------------------------
// The core takes one pixel coordinate in every clock cycle (busy is always
// low) and returns its color and density, one result per pixel, in order,
// each shown for one cycle with done high; the receiver must take it then.
// The pipeline has 18 stages: coordinate scaling, the per-octave lattice
// hash, two blend steps, the octave sum and normalization, and the color
// blend. All octaves run as parallel lanes. A write to noise_seed reaches
// the coordinate offset through the seed product and offset registers.
module fractal_value_noise_cloud_pixel_core
    import fvn_pkg::*;
#(
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] pixel_column,
    input  logic [15:0] pixel_row,
    input  logic        write_en,
    input  logic [2:0]  write_index,
    input  logic [31:0] write_data,
    output logic        done,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [15:0] density
);

    localparam int DEPTH = 18;
    localparam int POS_W = COORD_BITS + FRAC_BITS;
    localparam int UW    = 16 + MAX_OCTAVES;
    localparam int SW    = 16 + MAX_OCTAVES;
    localparam int DW    = FRAC_BITS + 18;

    // Reciprocal of 1000 for the seed offset, exact for 32-bit values.
    localparam logic [31:0] RECIP_1000 = 32'd2199023256;
    // Reciprocal of 150 with a shift of 25, exact for 17-bit values.
    localparam logic [17:0] RECIP_150  = 18'd223697;

    typedef logic [FRAC_BITS-1:0] frac_arr_t [0:149];

    // Fraction of remainder r divided by 150.
    function automatic frac_arr_t build_frac();
        frac_arr_t tab;
        for (int r = 0; r < 150; r++)
        begin
            tab[r] = FRAC_BITS'((64'(r) << FRAC_BITS) / 150);
        end
        return tab;
    endfunction

    localparam frac_arr_t  FRAC_TAB  = build_frac();

    // floor(2^UW / (2^k - 1)) for each octave count k.
    logic [UW:0] recip_tab [0:MAX_OCTAVES];
    assign recip_tab[0] = '0;

    for (genvar k = 1; k <= MAX_OCTAVES; k++)
    begin : g_recip
        localparam logic [UW:0] RECIP =
            (UW+1)'((64'(1) << UW) / ((64'(1) << k) - 64'd1));
        assign recip_tab[k] = RECIP;
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [31:0]      noise_seed_reg;
    logic [OCT_W-1:0] octave_count_reg;
    logic [7:0]       first_red_reg, first_green_reg, first_blue_reg;
    logic [7:0]       second_red_reg, second_green_reg, second_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_seed_reg   <= '0;
            octave_count_reg <= OCT_W'(6);
            first_red_reg    <= '0;
            first_green_reg  <= '0;
            first_blue_reg   <= '0;
            second_red_reg   <= 8'hFF;
            second_green_reg <= 8'hFF;
            second_blue_reg  <= 8'hFF;
        end
        else if (write_en)
        begin
            unique case (reg_index_t'(write_index))
                REG_NOISE_SEED:   noise_seed_reg   <= write_data;
                REG_OCTAVE_COUNT: octave_count_reg <= write_data[OCT_W-1:0];
                REG_FIRST_RED:    first_red_reg    <= write_data[7:0];
                REG_FIRST_GREEN:  first_green_reg  <= write_data[7:0];
                REG_FIRST_BLUE:   first_blue_reg   <= write_data[7:0];
                REG_SECOND_RED:   second_red_reg   <= write_data[7:0];
                REG_SECOND_GREEN: second_green_reg <= write_data[7:0];
                REG_SECOND_BLUE:  second_blue_reg  <= write_data[7:0];
                default:          ;
            endcase
        end
    end

    // Octave count saturated into one to the maximum.
    logic [OCT_W-1:0] oct_k;
    logic [UW:0]      oct_div;
    always_comb
    begin
        if (octave_count_reg == '0)
            oct_k = OCT_W'(1);
        else if (octave_count_reg > OCT_W'(MAX_OCTAVES))
            oct_k = OCT_W'(MAX_OCTAVES);
        else
            oct_k = octave_count_reg;
        oct_div = ((UW+1)'(1) << oct_k) - (UW+1)'(1);
    end

    // Seed offset: seed mod 1000 through a registered reciprocal multiply.
    logic [63:0] seed_prod_reg;
    logic [9:0]  offset_reg;
    logic [22:0] seed_quot;
    assign seed_quot = seed_prod_reg[63:41];

    always_ff @(posedge clk)
    begin
        seed_prod_reg <= noise_seed_reg * RECIP_1000;
        offset_reg    <= 10'(noise_seed_reg - 32'(seed_quot * 32'd1000));
    end

    // ------------------------------------------------------------------
    // Valid bits travel alongside the pipeline data.
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    assign valid_next = {valid_reg[DEPTH-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign busy = 1'b0;
    assign done = valid_reg[DEPTH-1];

    // ------------------------------------------------------------------
    // Stages 1 to 3: offset and scale the coordinate by 1/150.
    logic [16:0]      col1_reg, row1_reg;
    logic [16:0]      col2_reg, row2_reg;
    logic [34:0]      colp2_reg, rowp2_reg;
    logic [POS_W-1:0] px3_reg, py3_reg;
    logic [9:0]       col_quot, row_quot;
    logic [7:0]       col_rem, row_rem;

    always_comb
    begin
        col_quot = colp2_reg[34:25];
        row_quot = rowp2_reg[34:25];
        col_rem  = 8'(col2_reg - 17'(col_quot * 17'd150));
        row_rem  = 8'(row2_reg - 17'(row_quot * 17'd150));
    end

    always_ff @(posedge clk)
    begin
        col1_reg  <= 17'(pixel_column) + 17'(offset_reg);
        row1_reg  <= 17'(pixel_row) + 17'(offset_reg);
        col2_reg  <= col1_reg;
        row2_reg  <= row1_reg;
        colp2_reg <= col1_reg * RECIP_150;
        rowp2_reg <= row1_reg * RECIP_150;
        px3_reg   <= POS_W'({col_quot, FRAC_TAB[col_rem]});
        py3_reg   <= POS_W'({row_quot, FRAC_TAB[row_rem]});
    end

    // ------------------------------------------------------------------
    // Stages 4 to 12: one lane per octave.
    logic [31:0]          mx4_reg  [MAX_OCTAVES];
    logic [31:0]          my4_reg  [MAX_OCTAVES];
    logic [FRAC_BITS-1:0] sx_reg   [MAX_OCTAVES][5];
    logic [FRAC_BITS-1:0] sy_reg   [MAX_OCTAVES][7];
    noise_value_t         corner   [MAX_OCTAVES][4];
    logic signed [DW-1:0] dx0_reg  [MAX_OCTAVES];
    logic signed [DW-1:0] dx1_reg  [MAX_OCTAVES];
    noise_value_t         n00_reg  [MAX_OCTAVES];
    noise_value_t         n01_reg  [MAX_OCTAVES];
    noise_value_t         top_reg  [MAX_OCTAVES];
    noise_value_t         bot_reg  [MAX_OCTAVES];
    noise_value_t         top2_reg [MAX_OCTAVES];
    logic signed [DW-1:0] dy_reg   [MAX_OCTAVES];
    noise_value_t         ov_reg   [MAX_OCTAVES];

    for (genvar g = 0; g < MAX_OCTAVES; g++)
    begin : g_lane
        logic [POS_W-1:0]     qx, qy;
        logic [31:0]          x0, y0;
        logic [31:0]          mx1, my1;
        logic signed [DW-1:0] top_full, bot_full, ov_full;

        // Octave position, lattice corner and fraction.
        always_comb
        begin
            qx  = POS_W'(px3_reg << g);
            qy  = POS_W'(py3_reg << g);
            x0  = 32'(qx[POS_W-1:FRAC_BITS]);
            y0  = 32'(qy[POS_W-1:FRAC_BITS]);
            mx1 = mx4_reg[g] + HASH_MUL_X;
            my1 = my4_reg[g] + HASH_MUL_Y;
        end

        // Hash of the four corners, the neighbors sharing the products.
        fvn_hash u_h00 (.clk(clk), .key(mx4_reg[g] + my4_reg[g] + noise_seed_reg),
                        .value(corner[g][0]));
        fvn_hash u_h10 (.clk(clk), .key(mx1 + my4_reg[g] + noise_seed_reg),
                        .value(corner[g][1]));
        fvn_hash u_h01 (.clk(clk), .key(mx4_reg[g] + my1 + noise_seed_reg),
                        .value(corner[g][2]));
        fvn_hash u_h11 (.clk(clk), .key(mx1 + my1 + noise_seed_reg),
                        .value(corner[g][3]));

        // Floor-shifted blend sums.
        always_comb
        begin
            top_full = DW'(n00_reg[g]) + (dx0_reg[g] >>> FRAC_BITS);
            bot_full = DW'(n01_reg[g]) + (dx1_reg[g] >>> FRAC_BITS);
            ov_full  = DW'(top2_reg[g]) + (dy_reg[g] >>> FRAC_BITS);
        end

        always_ff @(posedge clk)
        begin
            mx4_reg[g]   <= 32'(x0 * HASH_MUL_X);
            my4_reg[g]   <= 32'(y0 * HASH_MUL_Y);
            sx_reg[g][0] <= qx[FRAC_BITS-1:0];
            sy_reg[g][0] <= qy[FRAC_BITS-1:0];
            for (int s = 1; s < 5; s++)
                sx_reg[g][s] <= sx_reg[g][s-1];
            for (int s = 1; s < 7; s++)
                sy_reg[g][s] <= sy_reg[g][s-1];

            // Column blend products.
            dx0_reg[g] <= DW'((17'(corner[g][1]) - 17'(corner[g][0]))
                              * $signed({1'b0, sx_reg[g][4]}));
            dx1_reg[g] <= DW'((17'(corner[g][3]) - 17'(corner[g][2]))
                              * $signed({1'b0, sx_reg[g][4]}));
            n00_reg[g] <= corner[g][0];
            n01_reg[g] <= corner[g][2];

            top_reg[g] <= 16'(top_full);
            bot_reg[g] <= 16'(bot_full);

            // Row blend product.
            dy_reg[g]   <= DW'((17'(bot_reg[g]) - 17'(top_reg[g]))
                               * $signed({1'b0, sy_reg[g][6]}));
            top2_reg[g] <= top_reg[g];

            ov_reg[g] <= 16'(ov_full);
        end
    end

    // ------------------------------------------------------------------
    // Stages 13 to 16: weight, sum and normalize the octaves.
    logic signed [SW-1:0] w_reg [MAX_OCTAVES];
    logic [UW-1:0]        u_reg, u2_reg;
    logic [2*UW:0]        qprod_reg;
    logic [15:0]          t_reg;
    logic signed [UW:0]   u_sum;
    logic [16:0]          q0;
    logic [UW:0]          rem;

    always_comb
    begin
        // The bias of 32768 per unit weight makes the sum non-negative.
        u_sum = $signed(oct_div << 15);
        for (int i = 0; i < MAX_OCTAVES; i++)
            u_sum = u_sum + (UW+1)'(w_reg[i]);
        q0  = 17'(qprod_reg >> UW);
        rem = (UW+1)'(u2_reg) - (((UW+1)'(q0) << oct_k) - (UW+1)'(q0));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_OCTAVES; i++)
        begin
            if (OCT_W'(i) < oct_k)
                w_reg[i] <= SW'(ov_reg[i]) <<< (oct_k - OCT_W'(1) - OCT_W'(i));
            else
                w_reg[i] <= '0;
        end
        u_reg     <= UW'(u_sum);
        qprod_reg <= (2*UW+1)'(u_reg * recip_tab[oct_k]);
        u2_reg    <= u_reg;
        // The estimate is at most one low.
        t_reg     <= (rem >= oct_div) ? 16'(q0 + 17'd1) : 16'(q0);
    end

    // ------------------------------------------------------------------
    // Stages 17 and 18: blend the colors and divide by 65535.
    logic [23:0] pa_reg [3];
    logic [23:0] pb_reg [3];
    logic [15:0] t2_reg;
    logic [7:0]  ch_out [3];
    logic [7:0]  c1     [3];
    logic [7:0]  c2     [3];

    always_comb
    begin
        c1[0] = first_red_reg;
        c1[1] = first_green_reg;
        c1[2] = first_blue_reg;
        c2[0] = second_red_reg;
        c2[1] = second_green_reg;
        c2[2] = second_blue_reg;
        for (int c = 0; c < 3; c++)
        begin
            logic [24:0] nsum;
            logic [8:0]  nq;
            logic [16:0] nr;
            nsum = 25'(pa_reg[c]) + 25'(pb_reg[c]);
            nq   = nsum[24:16];
            // n = 65535 * q + (q + low half).
            nr   = 17'(nsum[15:0]) + 17'(nq);
            ch_out[c] = (nr >= 17'd65535) ? 8'(nq + 9'd1) : 8'(nq);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            pa_reg[c] <= c1[c] * (16'hFFFF - t_reg);
            pb_reg[c] <= c2[c] * t_reg;
        end
        t2_reg    <= t_reg;
        out_red   <= ch_out[0];
        out_green <= ch_out[1];
        out_blue  <= ch_out[2];
        density   <= t2_reg;
    end

endmodule

/* rtl/fvn_hash.sv */
// ----------------------------------------------------------------------------
// fvn_hash
// Four-stage pipelined lattice hash: one mixed key in, one Q1.15 value out.
// ----------------------------------------------------------------------------
module fvn_hash
    import fvn_pkg::*;
(
    input  logic         clk,
    input  logic [31:0]  key,
    output noise_value_t value
);

    logic [31:0] fold_reg;
    logic [31:0] mix_reg;
    logic [31:0] mul_reg;
    logic [31:0] fold2;
    logic [31:0] fold3;

    // Second and third fold steps of the hash.
    assign fold2 = mix_reg ^ (mix_reg >> HASH_SHIFT);
    assign fold3 = mul_reg ^ (mul_reg >> HASH_SHIFT);

    // A register after each step; the second and third stages hold one multiply each.
    always_ff @(posedge clk)
    begin
        fold_reg <= key ^ (key >> HASH_SHIFT);
        mix_reg  <= 32'(fold_reg * HASH_MUL_MIX);
        mul_reg  <= 32'(fold2 * HASH_MUL_Y);
        // Bits 30..15 minus 32768 is the same as inverting the top bit.
        value    <= $signed({~fold3[30], fold3[29:15]});
    end

endmodule

/* test/tb_fractal_value_noise_cloud_pixel_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fractal_value_noise_cloud_pixel_core
// Self-checking bench for the cloud pixel core: pixel coordinates are sent
// under several register settings, and each colored pixel is compared with a
// bit-exact predictor of the fractal value noise and the color blend.
// ----------------------------------------------------------------------------
module tb_fractal_value_noise_cloud_pixel_core;
    import fvn_pkg::*;

    localparam int  LATENCY   = 18;
    localparam int  MAX_OCT   = 8;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] dens;
    } pixel_color_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] pixel_column;
    logic [15:0] pixel_row;
    logic        write_en;
    logic [2:0]  write_index;
    logic [31:0] write_data;
    logic        done;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [15:0] density;

    // Shadow copy of the configuration registers.
    logic [31:0] seed_reg;
    logic [3:0]  octaves_reg;
    logic [7:0]  color_a [3];
    logic [7:0]  color_b [3];

    pixel_color_t pending_pixels [$];
    int  error_count;
    int  send_idle_pct;
    longint cycle_count;

    fractal_value_noise_cloud_pixel_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .write_en     (write_en),
        .write_index  (write_index),
        .write_data   (write_data),
        .done         (done),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .density      (density)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Lattice corner value in signed Q1.15.
    function automatic longint lattice_value(logic [31:0] x, logic [31:0] y);
        logic [31:0] h;
        h = x * HASH_MUL_X + y * HASH_MUL_Y + seed_reg;
        h = (h ^ (h >> 15)) * HASH_MUL_MIX;
        h = h ^ (h >> 15);
        h = h * HASH_MUL_Y;
        h = h ^ (h >> 15);
        return longint'((h & 32'h7FFF_FFFF) >> 15) - 32768;
    endfunction

    // Exact linear interpolation with floor on the fraction product.
    function automatic longint lerp_floor(longint a, longint b, longint s);
        return a + ((b - a) * s >>> 16);
    endfunction

    function automatic pixel_color_t cloud_pixel(logic [15:0] col, logic [15:0] row);
        longint offset, px, py, qx, qy, sum, norm, tv, top, bot, d;
        logic [31:0] x0, y0;
        int k;
        pixel_color_t res;
        offset = longint'(seed_reg % 1000);
        px = (((longint'(col) + offset) << 16) / 150) & 64'hFFFF_FFFF;
        py = (((longint'(row) + offset) << 16) / 150) & 64'hFFFF_FFFF;
        k = octaves_reg;
        if (k < 1) k = 1;
        if (k > MAX_OCT) k = MAX_OCT;
        sum = 0;
        for (int i = 0; i < k; i++)
        begin
            qx = (px << i) & 64'hFFFF_FFFF;
            qy = (py << i) & 64'hFFFF_FFFF;
            x0 = qx[47:16];
            y0 = qy[47:16];
            top = lerp_floor(lattice_value(x0, y0), lattice_value(x0 + 1, y0),
                             qx & 16'hFFFF);
            bot = lerp_floor(lattice_value(x0, y0 + 1), lattice_value(x0 + 1, y0 + 1),
                             qx & 16'hFFFF);
            sum += lerp_floor(top, bot, qy & 16'hFFFF) * (longint'(1) << (k - 1 - i));
        end
        d = (longint'(1) << k) - 1;
        norm = sum / d;
        if ((sum % d) != 0 && sum < 0) norm--;
        tv = norm + 32768;
        if (tv < 0) tv = 0;
        if (tv > 65535) tv = 65535;
        res.red   = 8'((color_a[0] * (65535 - tv) + color_b[0] * tv) / 65535);
        res.green = 8'((color_a[1] * (65535 - tv) + color_b[1] * tv) / 65535);
        res.blue  = 8'((color_a[2] * (65535 - tv) + color_b[2] * tv) / 65535);
        res.dens  = tv[15:0];
        return res;
    endfunction

    // Compare each output pixel with the oldest prediction.
    always @(posedge clk)
    begin
        pixel_color_t exp_px;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result transaction");
                error_count++;
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                if (out_red !== exp_px.red)
                begin
                    $error("out_red expected %0d actual %0d", exp_px.red, out_red);
                    error_count++;
                end
                if (out_green !== exp_px.green)
                begin
                    $error("out_green expected %0d actual %0d", exp_px.green, out_green);
                    error_count++;
                end
                if (out_blue !== exp_px.blue)
                begin
                    $error("out_blue expected %0d actual %0d", exp_px.blue, out_blue);
                    error_count++;
                end
                if (density !== exp_px.dens)
                begin
                    $error("density expected %0d actual %0d", exp_px.dens, density);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Register write, applied to the shadow copy with width truncation.
    // The caller drops write_en after the last write of a burst.
    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        write_en    <= 1'b1;
        write_index <= idx;
        write_data  <= value;
        @(posedge clk);
        case (idx)
            REG_NOISE_SEED:   seed_reg    = value;
            REG_OCTAVE_COUNT: octaves_reg = value[3:0];
            REG_FIRST_RED:    color_a[0]  = value[7:0];
            REG_FIRST_GREEN:  color_a[1]  = value[7:0];
            REG_FIRST_BLUE:   color_a[2]  = value[7:0];
            REG_SECOND_RED:   color_b[0]  = value[7:0];
            REG_SECOND_GREEN: color_b[1]  = value[7:0];
            default:          color_b[2]  = value[7:0];
        endcase
    endtask

    // Stop sending, wait until every prediction has been matched, then let
    // the pipe settle.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_all(logic [31:0] seed, logic [3:0] oct,
                             logic [23:0] ca, logic [23:0] cb);
        drain_pipeline();
        write_reg(REG_NOISE_SEED, seed);
        write_reg(REG_OCTAVE_COUNT, {28'h0, oct});
        write_reg(REG_FIRST_RED, {24'h0, ca[23:16]});
        write_reg(REG_FIRST_GREEN, {24'h0, ca[15:8]});
        write_reg(REG_FIRST_BLUE, {24'h0, ca[7:0]});
        write_reg(REG_SECOND_RED, {24'h0, cb[23:16]});
        write_reg(REG_SECOND_GREEN, {24'h0, cb[15:8]});
        write_reg(REG_SECOND_BLUE, {24'h0, cb[7:0]});
        write_en <= 1'b0;
        repeat (3) @(posedge clk);
    endtask

    // Send one pixel coordinate, with a random gap beforehand. Start stays
    // high after the transaction until the next gap or drain lowers it.
    task automatic send_pixel(logic [15:0] col, logic [15:0] row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        pixel_column <= col;
        pixel_row    <= row;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_pixels.push_back(cloud_pixel(col, row));
    endtask

    task automatic test_reset_defaults();
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'd149, 16'd150);
    endtask

    task automatic test_extremes();
        write_all(32'hFFFF_FFFF, 4'd8, 24'h000000, 24'hFFFFFF);
        send_pixel(16'd0, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'hAAAA, 16'h5555);
        // Octave count zero saturates to one octave.
        write_all(32'd0, 4'd0, 24'hFFFFFF, 24'h000000);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'h1234);
        // Octave count above the maximum saturates.
        write_all(32'd999, 4'd15, 24'h102030, 24'hF0E0D0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'd7, 16'd9);
        write_all(32'd1, 4'd1, 24'h808080, 24'h808080);
        send_pixel(16'h8000, 16'h7FFF);
        // Out-of-range data widths are truncated by the registers.
        drain_pipeline();
        write_reg(REG_OCTAVE_COUNT, 32'hFFFF_FFF3);
        write_reg(REG_FIRST_RED, 32'hABCD_EF12);
        write_en <= 1'b0;
        repeat (3) @(posedge clk);
        send_pixel(16'd300, 16'd450);
        send_pixel(16'd1, 16'd2);
    endtask

    task automatic test_random(int count);
        logic [15:0] col, row;
        for (int n = 0; n < count; n++)
        begin
            if (n % 200 == 0)
            begin
                write_all($urandom, 4'($urandom_range(MAX_OCT, 1)), 24'($urandom),
                          24'($urandom));
            end
            case ($urandom_range(3))
                0:
                begin
                    col = 16'($urandom_range(16'hFFFF));
                    row = 16'($urandom_range(16'hFFFF));
                end
                1:
                begin
                    col = 16'($urandom_range(400));
                    row = 16'($urandom_range(400));
                end
                2:
                begin
                    col = 16'(32'hFFFF - $urandom_range(1200));
                    row = 16'(32'hFFFF - $urandom_range(1200));
                end
                default:
                begin
                    col = 16'($urandom);
                    row = 16'(32'(col) + $urandom_range(3));
                end
            endcase
            send_pixel(col, row);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        pixel_column <= '0;
        pixel_row    <= '0;
        write_en     <= 1'b0;
        write_index  <= REG_NOISE_SEED;
        write_data   <= '0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 26;
        seed_reg      = 32'd0;
        octaves_reg   = 4'd6;
        color_a       = '{8'd0, 8'd0, 8'd0};
        color_b       = '{8'd255, 8'd255, 8'd255};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extremes();
        test_random(570);
        send_idle_pct = 59;
        test_random(560);
        send_idle_pct = 0;
        test_random(560);
        drain_pipeline();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* fractal_value_noise_cloud_pixel_core.f */
rtl/fvn_pkg.sv
rtl/fvn_hash.sv
rtl/fractal_value_noise_cloud_pixel_core.sv
test/tb_fractal_value_noise_cloud_pixel_core.sv
